// ===== rtl/tpog_pkg.sv =====
`default_nettype none

package tpog_pkg;

  localparam int IN_W       = 31;
  localparam int CFG_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int DEPTH_W    = 4;
  localparam int CHAR_W     = 7;
  localparam int IDX_OFS_W  = 19;
  localparam int SIZE_OFS_W = 20;
  localparam int REM_W      = 8;
  localparam int N_W        = 16;
  localparam int WH_W       = 17;
  localparam int DIG_W      = 6;
  localparam int PAIR_W     = 4;
  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 48;

  localparam int MAX_PATH_LEN_DEF = 31;
  localparam int COORD_BITS_DEF   = 31;

  localparam logic [CFG_W-1:0]   DIV_MAX     = 9'd256;
  localparam logic [CFG_W-1:0]   WIDE_RESET  = 9'd16;
  localparam logic [CFG_W-1:0]   HIGH_RESET  = 9'd16;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd2;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 4'd8;
  localparam logic [DIG_W-1:0]   RADIX       = 6'd36;
  localparam logic [DIG_W-1:0]   HALF_RADIX  = 6'd18;
  localparam int                 TABLE_BASE  = 1024;

  localparam logic [CHAR_W-1:0] CH_SLASH = 7'h2F;
  localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] CH_T     = 7'h74;
  localparam logic [CHAR_W-1:0] CH_I     = 7'h69;
  localparam logic [CHAR_W-1:0] CH_F     = 7'h66;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 7'h37;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDE  = 2'd0,
    CFG_HIGH  = 2'd1,
    CFG_DEPTH = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CALC,
    S_OFS,
    S_EMIT
  } top_state_e;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SLASH,
    PH_XDIG,
    PH_YDIG,
    PH_DOT,
    PH_T,
    PH_I,
    PH_F
  } emit_phase_e;

  typedef struct packed {
    logic                start;
    logic [PAIR_W-1:0]   pairs;
    logic [DEPTH_W-1:0]  depth;
  } emit_ctrl_t;

  function automatic int b36_digits(input int bits);
    longint lim;
    longint p;
    int     n;
    lim = longint'(1) << bits;
    p   = 36;
    n   = 1;
    while (p < lim) begin
      p = p * 36;
      n++;
    end
    return n;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] v);
    if (v < 6'd10) begin
      return CHAR_W'(v) + CH_ZERO;
    end
    return CHAR_W'(v) + CH_ALPHA;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tile_path_and_offset_gen.sv =====
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tile_col, tile_row
// m_axis    out        m_axis_tvalid/m_axis_tready  path_char, index_offset, size_offset; tlast
// cfg       in         cfg_we_i                     cfg_idx_i selects, cfg_data_i
//
// After a tile is taken, the two bit-serial dividers run over its CW coordinate bits,
// where CW is COORD_BITS capped at 31; then S_CALC and S_OFS come before the first character.
// While m_axis_tready is high, one character per cycle follows, 7 to MAX_PATH_LEN characters.
// Reset loads the registers with 16, 16 and 2 and clears the control state and remainders.
// A stalled output holds its character; input is taken only when idle.
`default_nettype none

module tile_path_and_offset_gen import tpog_pkg::*; #(
  parameter int MAX_PATH_LEN = MAX_PATH_LEN_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tile_col [30:0], tile_row [61:31], zero [63:62]
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // path_char [6:0], index_offset [25:7], size_offset [45:26], zero [47:46]
  output logic [M_TDATA_W-1:0]       m_axis_tdata,
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i
);

  localparam int CW    = (COORD_BITS < IN_W) ? COORD_BITS : IN_W;
  localparam int ND    = b36_digits(CW);
  localparam int CNT_W = $clog2(CW);

  top_state_e state_q, state_d;

  logic [CFG_W-1:0]   wide_q, high_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [CFG_W-1:0]   w_clamp, h_clamp;
  logic [DEPTH_W-1:0] d_clamp;

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               load, step, calc, ofs;
  logic               done;

  logic               xq, yq;
  logic [REM_W-1:0]   xrem, yrem;
  logic [ND-1:0][DIG_W-1:0] x_dig, y_dig;

  logic [N_W-1:0]        n_q;
  logic [WH_W-1:0]       wh_q;
  logic [PAIR_W-1:0]     pairs_q;
  logic [IDX_OFS_W-1:0]  idx_q;
  logic [SIZE_OFS_W-1:0] sz_q;
  logic [WH_W-1:0]       n_sum;
  logic [PAIR_W-1:0]     ndig;
  logic [PAIR_W-1:0]     pairs_d;
  emit_ctrl_t            ectrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q  <= WIDE_RESET;
      high_q  <= HIGH_RESET;
      depth_q <= DEPTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDE:  wide_q  <= cfg_data_i;
        CFG_HIGH:  high_q  <= cfg_data_i;
        CFG_DEPTH: depth_q <= cfg_data_i[DEPTH_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    w_clamp = (wide_q == '0) ? CFG_W'(1) : ((wide_q > DIV_MAX) ? DIV_MAX : wide_q);
    h_clamp = (high_q == '0) ? CFG_W'(1) : ((high_q > DIV_MAX) ? DIV_MAX : high_q);
    d_clamp = (depth_q > DEPTH_MAX) ? DEPTH_MAX : depth_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    s_axis_tready = 1'b0;
    load          = 1'b0;
    step          = 1'b0;
    calc          = 1'b0;
    ofs           = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          load    = 1'b1;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        step  = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(CW - 1)) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        calc    = 1'b1;
        state_d = S_OFS;
      end
      S_OFS: begin
        ofs     = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  tpog_div #(.CW(CW)) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .step_i     (step),
    .dividend_i (s_axis_tdata[CW-1:0]),
    .divisor_i  (w_clamp),
    .qbit_o     (xq),
    .rem_o      (xrem)
  );

  tpog_div #(.CW(CW)) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .step_i     (step),
    .dividend_i (s_axis_tdata[IN_W+CW-1:IN_W]),
    .divisor_i  (h_clamp),
    .qbit_o     (yq),
    .rem_o      (yrem)
  );

  tpog_b36 #(.ND(ND)) u_b36_x (
    .clk_i   (clk_i),
    .clr_i   (load),
    .shift_i (step),
    .bit_i   (xq),
    .dig_o   (x_dig)
  );

  tpog_b36 #(.ND(ND)) u_b36_y (
    .clk_i   (clk_i),
    .clr_i   (load),
    .shift_i (step),
    .bit_i   (yq),
    .dig_o   (y_dig)
  );

  always_comb begin
    ndig = PAIR_W'(1);
    for (int i = 0; i < ND; i++) begin
      if ((x_dig[i] != '0) || (y_dig[i] != '0)) begin
        ndig = PAIR_W'(i + 1);
      end
    end
    pairs_d = ((d_clamp + 1'b1) > ndig) ? (d_clamp + 1'b1) : ndig;
    n_sum   = WH_W'(yrem) * WH_W'(w_clamp) + WH_W'(xrem);
  end

  always_ff @(posedge clk_i) begin
    if (calc) begin
      n_q     <= n_sum[N_W-1:0];
      wh_q    <= WH_W'(WH_W'(w_clamp) * WH_W'(h_clamp));
      pairs_q <= pairs_d;
    end
    if (ofs) begin
      idx_q <= IDX_OFS_W'(TABLE_BASE) + {1'b0, n_q, 2'b00};
      sz_q  <= SIZE_OFS_W'(TABLE_BASE) + {2'b00, n_q, 2'b00} + {1'b0, wh_q, 2'b00};
    end
  end

  always_comb begin
    ectrl.start = ofs;
    ectrl.pairs = pairs_q;
    ectrl.depth = d_clamp;
  end

  tpog_emit #(.MAX_PATH_LEN(MAX_PATH_LEN), .ND(ND)) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ectrl),
    .x_dig_i       (x_dig),
    .y_dig_i       (y_dig),
    .idx_ofs_i     (idx_q),
    .size_ofs_i    (sz_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .done_o        (done)
  );

endmodule

`default_nettype wire

// ===== rtl/tpog_div.sv =====
`default_nettype none

// Restoring divider lane: one quotient bit per step, most significant first.
module tpog_div import tpog_pkg::*; #(
  parameter int CW = COORD_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire logic             step_i,
  input  wire logic [CW-1:0]    dividend_i,
  input  wire logic [CFG_W-1:0] divisor_i,
  output logic                  qbit_o,
  output logic [REM_W-1:0]      rem_o
);

  logic [CW-1:0]    num_q, num_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [CFG_W-1:0] trial;
  logic [CFG_W-1:0] diff;

  always_comb begin
    trial  = {rem_q, num_q[CW-1]};
    diff   = trial - divisor_i;
    qbit_o = (trial >= divisor_i);
    num_d  = num_q;
    rem_d  = rem_q;
    if (load_i) begin
      num_d = dividend_i;
      rem_d = '0;
    end else if (step_i) begin
      num_d = {num_q[CW-2:0], 1'b0};
      rem_d = qbit_o ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

  assign rem_o = rem_q;

endmodule

`default_nettype wire

// ===== rtl/tpog_b36.sv =====
`default_nettype none

// Base-36 accumulator: shifts in one binary bit per step, most significant first.
module tpog_b36 import tpog_pkg::*; #(
  parameter int ND = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       clr_i,
  input  wire logic                       shift_i,
  input  wire logic                       bit_i,
  output logic [ND-1:0][DIG_W-1:0]        dig_o
);

  logic [ND-1:0][DIG_W-1:0] dig_q, dig_d;
  logic [ND:0]              carry;
  logic [DIG_W:0]           dbl;

  always_comb begin
    dig_d    = dig_q;
    carry[0] = bit_i;
    dbl      = '0;
    for (int i = 0; i < ND; i++) begin
      carry[i+1] = (dig_q[i] >= HALF_RADIX);
      dbl        = {dig_q[i], carry[i]};
      if (clr_i) begin
        dig_d[i] = '0;
      end else if (shift_i) begin
        dig_d[i] = carry[i+1] ? DIG_W'(dbl - {1'b0, RADIX}) : dbl[DIG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

  assign dig_o = dig_q;

endmodule

`default_nettype wire

// ===== rtl/tpog_emit.sv =====
`default_nettype none

module tpog_emit import tpog_pkg::*; #(
  parameter int MAX_PATH_LEN = MAX_PATH_LEN_DEF,
  parameter int ND           = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire emit_ctrl_t                 ctrl_i,
  input  wire logic [ND-1:0][DIG_W-1:0]   x_dig_i,
  input  wire logic [ND-1:0][DIG_W-1:0]   y_dig_i,
  input  wire logic [IDX_OFS_W-1:0]       idx_ofs_i,
  input  wire logic [SIZE_OFS_W-1:0]      size_ofs_i,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // path_char [6:0], index_offset [25:7], size_offset [45:26], zero [47:46]
  output logic [M_TDATA_W-1:0]            m_axis_tdata,
  output logic                            m_axis_tlast,
  output logic                            done_o
);

  localparam int CNT_W = $clog2(MAX_PATH_LEN);
  localparam int IW    = (ND > 1) ? $clog2(ND) : 1;

  emit_phase_e       phase_q, phase_d;
  logic              valid_q, valid_d;
  logic [PAIR_W-1:0] pi_q, pi_d;
  logic [PAIR_W-1:0] pi_dec;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              xfer;
  logic              last;
  logic [DIG_W-1:0]  x_sel, y_sel;
  logic [CHAR_W-1:0] ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      valid_q <= 1'b0;
      pi_q    <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
      pi_q    <= pi_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    xfer    = valid_q && m_axis_tready;
    last    = (phase_q == PH_F) || (cnt_q == CNT_W'(MAX_PATH_LEN - 1));
    pi_dec  = pi_q - 1'b1;
    phase_d = phase_q;
    valid_d = valid_q;
    pi_d    = pi_q;
    cnt_d   = cnt_q;
    if (ctrl_i.start) begin
      valid_d = 1'b1;
      phase_d = PH_LEAD;
      pi_d    = ctrl_i.pairs - 1'b1;
      cnt_d   = '0;
    end else if (xfer) begin
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        valid_d = 1'b0;
      end
      case (phase_q)
        PH_LEAD:  phase_d = PH_XDIG;
        PH_SLASH: phase_d = PH_XDIG;
        PH_XDIG:  phase_d = PH_YDIG;
        PH_YDIG: begin
          if (pi_q == '0) begin
            phase_d = PH_DOT;
          end else begin
            pi_d    = pi_dec;
            phase_d = (pi_dec < ctrl_i.depth) ? PH_SLASH : PH_XDIG;
          end
        end
        PH_DOT:   phase_d = PH_T;
        PH_T:     phase_d = PH_I;
        PH_I:     phase_d = PH_F;
        PH_F:     phase_d = PH_F;
        default:  phase_d = PH_LEAD;
      endcase
    end
  end

  always_comb begin
    x_sel = '0;
    y_sel = '0;
    if (pi_q < PAIR_W'(ND)) begin
      x_sel = x_dig_i[pi_q[IW-1:0]];
      y_sel = y_dig_i[pi_q[IW-1:0]];
    end
    case (phase_q)
      PH_LEAD:  ch = CH_SLASH;
      PH_SLASH: ch = CH_SLASH;
      PH_XDIG:  ch = digit_char(x_sel);
      PH_YDIG:  ch = digit_char(y_sel);
      PH_DOT:   ch = CH_DOT;
      PH_T:     ch = CH_T;
      PH_I:     ch = CH_I;
      PH_F:     ch = CH_F;
      default:  ch = CH_SLASH;
    endcase
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = last;
  assign m_axis_tdata  = {(M_TDATA_W - SIZE_OFS_W - IDX_OFS_W - CHAR_W)'(0),
                          size_ofs_i, idx_ofs_i, ch};
  assign done_o        = xfer && last;

endmodule

`default_nettype wire

// ===== rtl/tpog_chk.sv =====
`default_nettype none

module tpog_chk import tpog_pkg::*; (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_axis_tvalid,
  input wire logic                 s_axis_tready,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                 m_axis_tlast
);

  // Only one tile is in flight: input is never offered while output is pending.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output valid");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  // Offsets stay the same over all characters of one path.
  a_ofs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid &&
       m_axis_tdata[M_TDATA_W-1:CHAR_W] == $past(m_axis_tdata[M_TDATA_W-1:CHAR_W])))
    else $error("offsets changed within a path");

  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output valid after the final character");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output changed");

endmodule

bind tile_path_and_offset_gen tpog_chk u_tpog_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== bench/tile_path_and_offset_gen_checker.sv =====
module tile_path_and_offset_gen_checker import tpog_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  input  wire logic                 s_axis_tready,
  // tile_col [30:0], tile_row [61:31], zero [63:62]
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  input  wire logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // path_char [6:0], index_offset [25:7], size_offset [45:26], zero [47:46]
  input  wire logic [M_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                 m_axis_tlast,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output int unsigned               mismatch_count_o,
  output int unsigned               chars_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [36*8-1:0] BASE36_CHARS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  typedef struct packed {
    logic [CHAR_W-1:0]     ch;
    logic                  last;
    logic [IDX_OFS_W-1:0]  idx_ofs;
    logic [SIZE_OFS_W-1:0] size_ofs;
  } path_char_t;

  path_char_t         expected_chars_q[$];
  logic [CFG_W-1:0]   wide_reg;
  logic [CFG_W-1:0]   high_reg;
  logic [DEPTH_W-1:0] depth_reg;

  initial mismatch_count_o = 0;

  function automatic logic [CHAR_W-1:0] base36_char(input int unsigned v);
    return BASE36_CHARS[(35 - v) * 8 +: CHAR_W];
  endfunction

  function automatic int unsigned clamp_divisor(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return 1;
    end else if (v > DIV_MAX) begin
      return DIV_MAX;
    end
    return v;
  endfunction

  function automatic void queue_tile_path(input logic [IN_W-1:0] col,
                                          input logic [IN_W-1:0] row);
    logic [CHAR_W-1:0] path_q[$];
    int unsigned       w, h, d, x, y, idx_ofs, size_ofs, emit;
    path_char_t        item;
    w = clamp_divisor(wide_reg);
    h = clamp_divisor(high_reg);
    d = (depth_reg > DEPTH_MAX) ? DEPTH_MAX : depth_reg;
    x = col / w;
    y = row / h;
    path_q.push_front(CH_F);
    path_q.push_front(CH_I);
    path_q.push_front(CH_T);
    path_q.push_front(CH_DOT);
    for (int unsigned i = 0; i < d; i++) begin
      path_q.push_front(base36_char(y % RADIX));
      path_q.push_front(base36_char(x % RADIX));
      path_q.push_front(CH_SLASH);
      x = x / RADIX;
      y = y / RADIX;
    end
    do begin
      path_q.push_front(base36_char(y % RADIX));
      path_q.push_front(base36_char(x % RADIX));
      x = x / RADIX;
      y = y / RADIX;
    end while (x != 0 || y != 0);
    path_q.push_front(CH_SLASH);
    emit = (path_q.size() > MAX_PATH_LEN_DEF) ? MAX_PATH_LEN_DEF : path_q.size();
    idx_ofs  = TABLE_BASE + 4 * ((row % h) * w + (col % w));
    size_ofs = idx_ofs + 4 * w * h;
    for (int unsigned k = 0; k < emit; k++) begin
      item.ch       = path_q[k];
      item.last     = (k == emit - 1);
      item.idx_ofs  = IDX_OFS_W'(idx_ofs);
      item.size_ofs = SIZE_OFS_W'(size_ofs);
      expected_chars_q.push_back(item);
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatch_count_o++;
  endtask

  task automatic check_path_char();
    path_char_t want;
    path_char_t got;
    got.ch       = m_axis_tdata[CHAR_W-1:0];
    got.last     = m_axis_tlast;
    got.idx_ofs  = m_axis_tdata[CHAR_W +: IDX_OFS_W];
    got.size_ofs = m_axis_tdata[CHAR_W + IDX_OFS_W +: SIZE_OFS_W];
    if (expected_chars_q.size() == 0) begin
      report_mismatch("unexpected path character", got.ch, '0);
      return;
    end
    want = expected_chars_q.pop_front();
    if (got.ch !== want.ch) begin
      report_mismatch("path_char", got.ch, want.ch);
    end
    if (got.last !== want.last) begin
      report_mismatch("last_char", got.last, want.last);
    end
    if (got.idx_ofs !== want.idx_ofs) begin
      report_mismatch("index_offset", got.idx_ofs, want.idx_ofs);
    end
    if (got.size_ofs !== want.size_ofs) begin
      report_mismatch("size_offset", got.size_ofs, want.size_ofs);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_reg  = WIDE_RESET;
      high_reg  = HIGH_RESET;
      depth_reg = DEPTH_RESET;
      expected_chars_q.delete();
      chars_pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WIDE: begin
            wide_reg = cfg_data_i;
          end
          CFG_HIGH: begin
            high_reg = cfg_data_i;
          end
          CFG_DEPTH: begin
            depth_reg = cfg_data_i[DEPTH_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_path_char();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        queue_tile_path(s_axis_tdata[IN_W-1:0], s_axis_tdata[2*IN_W-1:IN_W]);
      end
      chars_pending_o <= expected_chars_q.size();
    end
  end

endmodule

// ===== bench/tile_path_and_offset_gen_test.sv =====
module tile_path_and_offset_gen_test import tpog_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned     TILE_LATENCY = 1 + 31 + 2;
  localparam int unsigned     CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned     CHUNKS       = 9;
  localparam int unsigned     CHUNK_TILES  = 50;
  localparam logic [IN_W-1:0] MAX_COORD    = '1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // tile_col [30:0], tile_row [61:31], zero [63:62]
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // path_char [6:0], index_offset [25:7], size_offset [45:26], zero [47:46]
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  int unsigned mismatches;
  int unsigned chars_pending;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 84;

  tile_path_and_offset_gen DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  tile_path_and_offset_gen_checker path_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .chars_pending_o  (chars_pending)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tile_path_and_offset_gen regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_tile(input logic [IN_W-1:0] col, input logic [IN_W-1:0] row);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, row, col};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (chars_pending != 0);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic set_registers(input logic [CFG_W-1:0] wide, input logic [CFG_W-1:0] high,
                               input logic [CFG_W-1:0] depth);
    wait_for_drain();
    write_register(CFG_WIDE, wide);
    write_register(CFG_HIGH, high);
    write_register(CFG_DEPTH, depth);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] random_divisor();
    case ($urandom_range(5))
      0: return CFG_W'(1);
      1: return DIV_MAX;
      2: return '0;
      3: return CFG_W'($urandom());
      default: return CFG_W'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_depth();
    if ($urandom_range(1) == 0) begin
      return CFG_W'($urandom());
    end
    return CFG_W'($urandom_range(0, DEPTH_MAX));
  endfunction

  function automatic logic [IN_W-1:0] random_coord();
    case ($urandom_range(3))
      0: return IN_W'($urandom());
      1: return IN_W'($urandom_range(0, 2000));
      2: return IN_W'($urandom_range(0, 1 << 20));
      default: return MAX_COORD - IN_W'($urandom_range(0, 300));
    endcase
  endfunction

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_WIDE;
    cfg_data_i    = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_tile('0, '0);
    send_tile(MAX_COORD, MAX_COORD);
    send_tile(MAX_COORD, '0);
    send_tile('0, MAX_COORD);
    send_tile(31'h2AAA_AAAA, 31'h5555_5555);
    send_tile(31'd15, 31'd16);
    set_registers(9'd1, 9'd1, 9'd8);
    send_tile(MAX_COORD, MAX_COORD);
    send_tile('0, '0);
    send_tile(31'd35, 31'd1295);
    set_registers(9'd0, 9'h1FF, 9'd15);
    send_tile(MAX_COORD, 31'd12345);
    send_tile(31'd7, MAX_COORD);
    set_registers(DIV_MAX, DIV_MAX, 9'd0);
    send_tile(MAX_COORD, MAX_COORD);
    send_tile(31'd255, 31'd255);
    send_tile(31'd256, '0);
    set_registers(9'd257, 9'd3, 9'h1F3);
    send_tile(31'd1000, 31'd999);
    send_tile(MAX_COORD - 1'b1, 31'd1);
    set_registers(9'd7, 9'd200, 9'd1);
    send_tile(31'd6, 31'd199);
    send_tile(31'd7, 31'd200);

    for (int unsigned chunk = 0; chunk < CHUNKS; chunk++) begin
      set_registers(random_divisor(), random_divisor(), random_depth());
      case (chunk / 3)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int unsigned k = 0; k < CHUNK_TILES; k++) begin
        if (k == CHUNK_TILES / 2 && chunk % 2 == 0) begin
          wait_for_drain();
        end
        send_tile(random_coord(), random_coord());
      end
    end

    wait_for_drain();
    repeat (TILE_LATENCY) @(posedge clk_i);
    if (mismatches == 0 && chars_pending == 0) begin
      $display("tile_path_and_offset_gen regression: pass");
    end else begin
      $display("tile_path_and_offset_gen regression: fail");
    end
    $finish;
  end

endmodule
